// ----- rtl/core/flow_counter_table_defines.svh -----
// Assertion macros shared by the RTL.
`ifndef FLOW_COUNTER_TABLE_DEFINES_SVH
`define FLOW_COUNTER_TABLE_DEFINES_SVH

// Condition holds in the same cycle.
`define FCT_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Condition holds in the next cycle.
`define FCT_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/core/fct_pkg.sv -----
`timescale 1ns / 1ps
package fct_pkg;
    localparam int TABLE_DEPTH = 256;
    localparam int KEY_BITS    = 128;
    localparam int NUM_CELLS   = 4;
    localparam int BANK_DEPTH  = TABLE_DEPTH / NUM_CELLS;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int LANE_W      = $clog2(NUM_CELLS);
    localparam int ROW_W       = $clog2(BANK_DEPTH);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int CFG_ADDR_W  = 2;
    localparam logic [CFG_ADDR_W-1:0] CAPACITY_ADDR = 2'd0;
    localparam logic [CNT_W-1:0] CAPACITY_RESET = CNT_W'(TABLE_DEPTH);

    typedef logic [KEY_BITS-1:0] key_t;

    typedef enum logic [1:0] {
        STATUS_UPDATED  = 2'd0,
        STATUS_APPENDED = 2'd1,
        STATUS_RECYCLED = 2'd2,
        STATUS_CLEARED  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_CMP, S_DRD, S_HIT, S_MISS, S_OUT
    } state_t;

    typedef struct packed {
        logic        command;
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [63:0] conn_count;
        logic [63:0] in_packets;
        logic [63:0] in_octets;
        logic [63:0] out_packets;
        logic [63:0] out_octets;
        logic [7:0]  flag_bits;
        logic [63:0] ext_addr_high;
        logic [63:0] ext_addr_low;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  entry_index;
        logic [63:0] total_count;
        logic [63:0] total_in_packets;
        logic [63:0] total_in_octets;
        logic [63:0] total_out_packets;
        logic [63:0] total_out_octets;
        logic [7:0]  total_flags;
    } rsp_t;

    typedef struct packed {
        logic [63:0] cnt;
        logic [63:0] in_pkt;
        logic [63:0] in_byt;
        logic [63:0] out_pkt;
        logic [63:0] out_byt;
        logic [7:0]  flags;
        logic [63:0] ext_high;
        logic [63:0] ext_low;
    } rec_t;

    typedef struct packed {
        logic              hit;
        logic [LANE_W-1:0] lane;
    } chain_t;
endpackage

// ----- rtl/core/fct_req_if.sv -----
`timescale 1ns / 1ps
interface fct_req_if;
    import fct_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/fct_rsp_if.sv -----
`timescale 1ns / 1ps
interface fct_rsp_if;
    import fct_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/fct_ram.sv -----
`timescale 1ns / 1ps
module fct_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/core/fct_cell.sv -----
`timescale 1ns / 1ps
module fct_cell (
    input  logic                        clk,
    input  logic                        we,
    input  logic [fct_pkg::ROW_W-1:0]   waddr,
    input  fct_pkg::key_t               wkey,
    input  logic [fct_pkg::ROW_W-1:0]   raddr,
    input  fct_pkg::key_t               probe,
    input  logic                        en,
    input  logic [fct_pkg::LANE_W-1:0]  lane_id,
    input  fct_pkg::chain_t             chain_in,
    output fct_pkg::chain_t             chain_out
);
    import fct_pkg::*;

    key_t stored;

    fct_ram #(.W(KEY_BITS), .D(BANK_DEPTH)) u_keys (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wkey),
        .raddr (raddr),
        .rdata (stored)
    );

    // pass an earlier hit, else claim the match
    always_comb
    begin
        chain_out = chain_in;
        if (!chain_in.hit && en && stored == probe)
        begin
            chain_out.hit  = 1'b1;
            chain_out.lane = lane_id;
        end
    end
endmodule

// ----- rtl/core/flow_counter_table.sv -----
`timescale 1ns / 1ps
// flow_counter_table: flow accounting table with round-robin replacement.
// Requests arrive on req (valid/ready); each gives one result on rsp.
// An accumulate request searches the stored keys four slots per row, one
// row after another, through a chain of four compare cells, each with
// its own key bank; the first match in slot order wins. A hit reads the
// counter record, adds the deltas and writes it back; a miss appends or
// recycles the oldest slot. A clear request empties the table at once.
// One request is in work at a time; req is ready only between requests.
// The result sits in an output register; while rsp stalls, the next
// request is taken and searched, and it waits only to hand its result over.
// Capacity (APB address 0, 9 bits, reset 256) is written by the user only
// while idle; the block itself does not enforce this. 0 acts as 1 and
// values above 256 as 256.
// Reset empties the table and sets capacity to 256; no clearing pass.
module flow_counter_table (
    input  logic                          clk,
    input  logic                          rst_n,
    fct_req_if.sink                       req,
    fct_rsp_if.source                     rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fct_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import fct_pkg::*;
`include "flow_counter_table_defines.svh"

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [SLOT_W-1:0] wo_reg, wo_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    req_t              item_reg;
    key_t              key_reg;
    rsp_t              res_reg, res_next;
    rsp_t              out_reg;
    logic              out_valid_reg;

    logic [CNT_W-1:0]  eff_cap;
    logic [2*64-1:0]   full_key;
    chain_t            chain [NUM_CELLS+1];
    logic              key_we;
    logic              data_we;
    rec_t              wrec, rrec;
    logic [CNT_W-1:0]  next_row_base;
    logic [CNT_W-1:0]  slot_inc;
    logic              take_out;

    assign pready = 1'b1;
    assign prdata = {{(32-CNT_W){1'b0}}, cap_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAPACITY_RESET;
        end
        else if (psel && penable && pwrite && paddr == CAPACITY_ADDR)
        begin
            cap_reg <= pwdata[CNT_W-1:0];
        end
    end

    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (cap_reg > CNT_W'(TABLE_DEPTH))
        begin
            eff_cap = CNT_W'(TABLE_DEPTH);
        end
        else
        begin
            eff_cap = cap_reg;
        end
    end

    assign full_key = {req.data.key_high, req.data.key_low};
    assign chain[0] = '0;

    for (genvar c = 0; c < NUM_CELLS; c++)
    begin : g_cell
        fct_cell u_cell (
            .clk       (clk),
            .we        (key_we && slot_next[LANE_W-1:0] == LANE_W'(c)),
            .waddr     (slot_next[SLOT_W-1:LANE_W]),
            .wkey      (key_reg),
            .raddr     (row_reg),
            .probe     (key_reg),
            .en        ({1'b0, row_reg, LANE_W'(c)} < used_reg),
            .lane_id   (LANE_W'(c)),
            .chain_in  (chain[c]),
            .chain_out (chain[c+1])
        );
    end

    fct_ram #(.W($bits(rec_t)), .D(TABLE_DEPTH)) u_data (
        .clk   (clk),
        .we    (data_we),
        .waddr (slot_next),
        .wdata (wrec),
        .raddr (slot_reg),
        .rdata (rrec)
    );

    assign req.ready     = (state_reg == S_IDLE);
    assign take_out      = !out_valid_reg || rsp.ready;
    assign next_row_base = {1'b0, row_reg + ROW_W'(1), {LANE_W{1'b0}}};

    always_comb
    begin
        state_next = state_reg;
        used_next  = used_reg;
        wo_next    = wo_reg;
        row_next   = row_reg;
        slot_next  = slot_reg;
        res_next   = res_reg;
        key_we     = 1'b0;
        data_we    = 1'b0;
        wrec       = rrec;
        slot_inc   = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    row_next = '0;
                    if (req.data.command)
                    begin
                        used_next  = '0;
                        wo_next    = '0;
                        res_next   = '0;
                        res_next.status = STATUS_CLEARED;
                        state_next = S_OUT;
                    end
                    else if (used_reg == '0)
                    begin
                        state_next = S_MISS;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (chain[NUM_CELLS].hit)
                begin
                    slot_next  = {row_reg, chain[NUM_CELLS].lane};
                    state_next = S_DRD;
                end
                else if (row_reg != ROW_W'(BANK_DEPTH - 1) && next_row_base < used_reg)
                begin
                    row_next   = row_reg + ROW_W'(1);
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_MISS;
                end
            end
            S_DRD:
            begin
                state_next = S_HIT;
            end
            S_HIT:
            begin
                wrec.cnt      = rrec.cnt + item_reg.conn_count;
                wrec.in_pkt   = rrec.in_pkt + item_reg.in_packets;
                wrec.in_byt   = rrec.in_byt + item_reg.in_octets;
                wrec.out_pkt  = rrec.out_pkt + item_reg.out_packets;
                wrec.out_byt  = rrec.out_byt + item_reg.out_octets;
                wrec.flags    = rrec.flags | item_reg.flag_bits;
                wrec.ext_high = item_reg.ext_addr_high;
                wrec.ext_low  = item_reg.ext_addr_low;
                data_we       = 1'b1;
                res_next.status = STATUS_UPDATED;
                state_next    = S_OUT;
            end
            S_MISS:
            begin
                if (used_reg < eff_cap)
                begin
                    slot_next = used_reg[SLOT_W-1:0];
                    used_next = used_reg + CNT_W'(1);
                    res_next.status = STATUS_APPENDED;
                end
                else
                begin
                    slot_next = ({1'b0, wo_reg} < eff_cap) ? wo_reg : '0;
                    res_next.status = STATUS_RECYCLED;
                end
                slot_inc = {1'b0, slot_next} + CNT_W'(1);
                wo_next  = (slot_inc >= eff_cap) ? '0 : slot_inc[SLOT_W-1:0];
                wrec.cnt      = item_reg.conn_count;
                wrec.in_pkt   = item_reg.in_packets;
                wrec.in_byt   = item_reg.in_octets;
                wrec.out_pkt  = item_reg.out_packets;
                wrec.out_byt  = item_reg.out_octets;
                wrec.flags    = item_reg.flag_bits;
                wrec.ext_high = item_reg.ext_addr_high;
                wrec.ext_low  = item_reg.ext_addr_low;
                key_we     = 1'b1;
                data_we    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (take_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (state_reg == S_HIT || state_reg == S_MISS)
        begin
            res_next.entry_index       = slot_next;
            res_next.total_count       = wrec.cnt;
            res_next.total_in_packets  = wrec.in_pkt;
            res_next.total_in_octets   = wrec.in_byt;
            res_next.total_out_packets = wrec.out_pkt;
            res_next.total_out_octets  = wrec.out_byt;
            res_next.total_flags       = wrec.flags;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            wo_reg        <= '0;
            row_reg       <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            wo_reg    <= wo_next;
            row_reg   <= row_next;
            slot_reg  <= slot_next;
            if (state_reg == S_OUT && take_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (req.valid && req.ready)
        begin
            item_reg <= req.data;
            key_reg  <= full_key[KEY_BITS-1:0];
        end
        if (state_reg == S_OUT && take_out)
        begin
            out_reg <= res_reg;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    `FCT_ASSERT_NOW(a_used_bound, 1'b1, used_reg <= CNT_W'(TABLE_DEPTH),
        "fill count beyond table depth")
    `FCT_ASSERT_NEXT(a_accept_busy, req.valid && req.ready, state_reg != S_IDLE,
        "request accepted but no work started")
    `FCT_ASSERT_NEXT(a_result_loaded, state_reg == S_OUT && take_out, rsp.valid,
        "finished request did not reach the output")
    `FCT_ASSERT_NOW(a_hit_in_range, state_reg == S_CMP && chain[NUM_CELLS].hit,
        {1'b0, row_reg, chain[NUM_CELLS].lane} < used_reg,
        "match on an unused slot")
endmodule

// ----- test/fct_tb_if.sv -----
`timescale 1ns / 1ps
// The block's own interfaces (fct_req_if, fct_rsp_if) are used directly;
// this file holds the result record the checker keeps in its queue.
package fct_tb_pkg;
    import fct_pkg::*;

    typedef struct {
        status_t     status;
        logic [7:0]  entry_index;
        logic [63:0] total_count;
        logic [63:0] total_in_packets;
        logic [63:0] total_in_octets;
        logic [63:0] total_out_packets;
        logic [63:0] total_out_octets;
        logic [7:0]  total_flags;
    } table_result_t;
endpackage

// ----- test/fct_checker.sv -----
`timescale 1ns / 1ps
module fct_checker
    import fct_pkg::*;
    import fct_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  req_t        req_data,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  rsp_t        rsp_data,
    input  logic        cfg_write,
    input  logic [31:0] cfg_value,
    output int          failures,
    output int          pending,
    output int          results_seen,
    output int          hits_seen,
    output int          recycles_seen
);
    logic [8:0]  capacity_reg;
    int          used;
    int          offset;
    logic [63:0] kh_tab [TABLE_DEPTH];
    logic [63:0] kl_tab [TABLE_DEPTH];
    logic [63:0] cnt_tab [5][TABLE_DEPTH];
    logic [7:0]  flag_tab [TABLE_DEPTH];
    table_result_t expected_results [$];

    assign pending = expected_results.size();

    function automatic table_result_t account_request(req_t r);
        table_result_t res;
        int eff_cap;
        int slot;
        bit hit;
        logic [63:0] deltas [5];
        deltas = '{r.conn_count, r.in_packets, r.in_octets, r.out_packets, r.out_octets};
        res = '{STATUS_CLEARED, 8'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 8'd0};
        if (r.command)
        begin
            used = 0;
            offset = 0;
            return res;
        end
        hit = 0;
        slot = 0;
        for (int i = 0; i < used; i++)
        begin
            if (!hit && kh_tab[i] == r.key_high && kl_tab[i] == r.key_low)
            begin
                hit = 1;
                slot = i;
            end
        end
        if (hit)
        begin
            for (int c = 0; c < 5; c++)
                cnt_tab[c][slot] += deltas[c];
            flag_tab[slot] |= r.flag_bits;
            res.status = STATUS_UPDATED;
        end
        else
        begin
            eff_cap = (capacity_reg == 0) ? 1 :
                      (capacity_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(capacity_reg);
            if (used < eff_cap)
            begin
                slot = used;
                used++;
                res.status = STATUS_APPENDED;
            end
            else
            begin
                slot = (offset < eff_cap) ? offset : 0;
                res.status = STATUS_RECYCLED;
            end
            offset = (slot + 1 >= eff_cap) ? 0 : slot + 1;
            kh_tab[slot] = r.key_high;
            kl_tab[slot] = r.key_low;
            for (int c = 0; c < 5; c++)
                cnt_tab[c][slot] = deltas[c];
            flag_tab[slot] = r.flag_bits;
        end
        res.entry_index       = slot[7:0];
        res.total_count       = cnt_tab[0][slot];
        res.total_in_packets  = cnt_tab[1][slot];
        res.total_in_octets   = cnt_tab[2][slot];
        res.total_out_packets = cnt_tab[3][slot];
        res.total_out_octets  = cnt_tab[4][slot];
        res.total_flags       = flag_tab[slot];
        return res;
    endfunction

    task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        table_result_t e;
        if (!rst_n)
        begin
            capacity_reg = 9'd256;
            used = 0;
            offset = 0;
            failures = 0;
            results_seen = 0;
            hits_seen = 0;
            recycles_seen = 0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_write)
                capacity_reg = cfg_value[8:0];
            if (rsp_valid && rsp_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result with no request outstanding");
                    failures++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (e.status == STATUS_UPDATED)
                        hits_seen++;
                    if (e.status == STATUS_RECYCLED)
                        recycles_seen++;
                    compare_field("status", e.status, rsp_data.status);
                    compare_field("entry_index", e.entry_index, rsp_data.entry_index);
                    compare_field("total_count", e.total_count, rsp_data.total_count);
                    compare_field("total_in_packets", e.total_in_packets,
                                  rsp_data.total_in_packets);
                    compare_field("total_in_octets", e.total_in_octets,
                                  rsp_data.total_in_octets);
                    compare_field("total_out_packets", e.total_out_packets,
                                  rsp_data.total_out_packets);
                    compare_field("total_out_octets", e.total_out_octets,
                                  rsp_data.total_out_octets);
                    compare_field("total_flags", e.total_flags, rsp_data.total_flags);
                end
            end
            if (req_valid && req_ready)
                expected_results.push_back(account_request(req_data));
        end
    end
endmodule

// ----- test/tb_flow_counter_table.sv -----
`timescale 1ns / 1ps
module tb_flow_counter_table;
    import fct_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          failures;
    int          pending;
    int          results_seen;
    int          hits_seen;
    int          recycles_seen;
    int          hold_cycles = 0;
    int          hold_asked = 0;
    int          hold_taken = 0;
    bit          stall_enable = 1;
    logic [63:0] key_pool [16];
    int          sent = 0;

    fct_req_if req ();
    fct_rsp_if rsp ();

    flow_counter_table dut (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    fct_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req.valid), .req_ready(req.ready), .req_data(req.data),
        .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data),
        .cfg_write(psel && penable && pwrite && pready && paddr == CAPACITY_ADDR),
        .cfg_value(pwdata),
        .failures(failures), .pending(pending), .results_seen(results_seen),
        .hits_seen(hits_seen), .recycles_seen(recycles_seen)
    );

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    // random stalls unless stall_enable is 0; full stall while hold_cycles runs
    always @(posedge clk)
    begin
        if (hold_taken != hold_asked)
        begin
            hold_taken <= hold_asked;
            hold_cycles <= 400;
            rsp.ready <= 0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            rsp.ready <= 0;
        end
        else if (!stall_enable)
            rsp.ready <= 1;
        else
            rsp.ready <= ($urandom_range(0, 9) < 7);
    end

    task automatic write_capacity(logic [31:0] value);
        @(posedge clk);
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= CAPACITY_ADDR;
        pwdata <= value;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic drain;
        while (pending != 0)
            @(posedge clk);
        repeat (140) @(posedge clk);
    endtask

    task automatic send_request(req_t r);
        req.valid <= 1;
        req.data <= r;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic idle_gap;
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        if (gap != 0)
        begin
            req.valid <= 0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic req_t random_request(int key_span);
        req_t r;
        int k;
        r.command = ($urandom_range(0, 60) == 0);
        k = $urandom_range(0, key_span - 1);
        if ($urandom_range(0, 9) == 0)
        begin
            r.key_high = rand64();
            r.key_low = rand64();
        end
        else
        begin
            r.key_high = key_pool[k % 16];
            r.key_low = 64'(k);
        end
        r.conn_count = rand64();
        r.in_packets = ($urandom_range(0, 3) == 0) ? rand64() : 64'($urandom_range(0, 100));
        r.in_octets = rand64();
        r.out_packets = ($urandom_range(0, 3) == 0) ? '1 : 64'($urandom_range(0, 100));
        r.out_octets = rand64();
        r.flag_bits = 8'($urandom());
        r.ext_addr_high = rand64();
        r.ext_addr_low = rand64();
        return r;
    endfunction

    function automatic req_t fixed_request(logic cmd, logic [63:0] kh, logic [63:0] kl,
                                           logic [63:0] v, logic [7:0] f);
        req_t r;
        r = '{cmd, kh, kl, v, v, v, v, v, f, v, ~v};
        return r;
    endfunction

    initial
    begin
        int caps [6];
        int burst;
        req.valid = 0;
        req.data = '0;
        caps = '{256, 1, 2, 5, 0, 300};
        for (int i = 0; i < 16; i++)
            key_pool[i] = rand64();
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, hits with wrap, clear, tiny table
        send_request(fixed_request(0, '0, '0, '0, 8'h00));
        send_request(fixed_request(0, '1, '1, '1, 8'hFF));
        send_request(fixed_request(0, '1, '1, 64'd1, 8'h01));
        send_request(fixed_request(0, '0, '0, '1, 8'h80));
        send_request(fixed_request(0, 64'h8000_0000_0000_0000, 64'd1, 64'h5555, 8'h55));
        send_request(fixed_request(0, 64'h8000_0000_0000_0000, 64'd1, 64'hAAAA, 8'hAA));
        send_request(fixed_request(1, '0, '0, '0, 8'h00));
        send_request(fixed_request(0, '1, '1, 64'd7, 8'h0F));
        req.valid <= 0;
        drain();
        write_capacity(32'd2);
        for (int i = 0; i < 6; i++)
            send_request(fixed_request(0, 64'd3, 64'(i % 3), 64'(i), 8'(1 << i)));
        req.valid <= 0;
        drain();
        // lower capacity below fill: old entries stay searchable
        write_capacity(32'd1);
        send_request(fixed_request(0, 64'd3, 64'd1, 64'd9, 8'h40));
        send_request(fixed_request(0, 64'd3, 64'd2, 64'd9, 8'h40));
        send_request(fixed_request(0, 64'd9, 64'd9, 64'd9, 8'h40));
        send_request(fixed_request(1, '1, '1, '1, 8'hFF));
        req.valid <= 0;
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_capacity(caps[ph]);
            if (ph == 2)
                stall_enable = 0;
            else
                stall_enable = 1;
            while (sent < 242 * (ph + 1))
            begin
                burst = $urandom_range(1, 20);
                for (int b = 0; b < burst; b++)
                begin
                    send_request(random_request(ph == 0 ? 300 : 40));
                    if (ph == 3 && b == 0 && hold_cycles == 0 && hold_taken == hold_asked &&
                        sent % 100 < 20)
                        hold_asked <= hold_asked + 1;
                end
                idle_gap();
            end
            req.valid <= 0;
            drain();
        end

        $display("Sent %0d requests, %0d results: %0d hits, %0d recycled slots.",
                 sent, results_seen, hits_seen, recycles_seen);
        $display("Capacities covered: 256, 2, 1, 5, 0 and 300, with clears and a long hold.");
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end
endmodule
